@@ rtl/vha_pkg.sv @@
// ----------------------------------------------------------------------------
// vha_pkg
// Shared types, constants and helpers for the versioned handle allocator.
// ----------------------------------------------------------------------------
package vha_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int VER_W  = 16;

    localparam logic OP_CREATE  = 1'b0;
    localparam logic OP_DESTROY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // One memory word holds both the free-list link and the version of a slot.
    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic [VER_W-1:0]  version;
    } t_slot_word;

    // Access request from the controller to the slot memory.
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_slot_word        wdata;
    } t_ram_req;

    // Versions count 1 .. max and wrap back to 1, never to 0.
    function automatic logic [VER_W-1:0] next_version(input logic [VER_W-1:0] v);
        logic [VER_W-1:0] nv;
        if (v == {VER_W{1'b1}}) begin
            nv = VER_W'(1);
        end else begin
            nv = v + VER_W'(1);
        end
        return nv;
    endfunction

endpackage

@@ rtl/vha_slot_ram.sv @@
// ----------------------------------------------------------------------------
// vha_slot_ram
// Slot table: one write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module vha_slot_ram
    import vha_pkg::*;
(
    input  logic       i_clk,
    input  t_ram_req   i_req,
    output t_slot_word o_rd_data
);

    t_slot_word r_mem [SLOTS];
    t_slot_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read data holds until the next read, so the controller may stall on it.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/vha_ctrl.sv @@
// ----------------------------------------------------------------------------
// vha_ctrl
// Sequencer: clearing pass, request read/modify/write and result register.
// ----------------------------------------------------------------------------
module vha_ctrl
    import vha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [SLOT_W-1:0] i_slot_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SLOT_W-1:0] o_handle_slot,
    output logic [VER_W-1:0]  o_handle_version,
    output logic              o_status,
    output t_ram_req          o_ram_req,
    input  t_slot_word        i_rd_data
);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr_cnt, n_clr_cnt;
    logic [LINK_W-1:0] r_free_head, n_free_head;
    logic              r_op;
    logic [SLOT_W-1:0] r_idx;
    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [VER_W-1:0]  r_out_ver, n_out_ver;
    logic              r_out_status, n_out_status;

    logic              in_fire;
    logic              exec_fire;
    logic [VER_W-1:0]  bumped_ver;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign exec_fire  = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign bumped_ver = next_version(i_rd_data.version);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_free_head <= n_free_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op  <= i_operation;
            r_idx <= i_slot_index;
        end
        r_out_slot   <= n_out_slot;
        r_out_ver    <= n_out_ver;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_free_head  = r_free_head;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_slot   = r_out_slot;
        n_out_ver    = r_out_ver;
        n_out_status = r_out_status;

        o_ram_req.re    = 1'b0;
        o_ram_req.raddr = (i_operation == OP_CREATE) ? r_free_head[SLOT_W-1:0]
                                                     : i_slot_index;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_idx;
        o_ram_req.wdata = '{link: r_free_head, version: bumped_ver};

        case (r_state)
            ST_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_clr_cnt;
                o_ram_req.wdata = '0;
                n_clr_cnt       = r_clr_cnt + SLOT_W'(1);
                if (r_clr_cnt == SLOT_W'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    o_ram_req.re = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (r_op == OP_CREATE) begin
                        if (r_free_head >= LINK_W'(SLOTS)) begin
                            n_out_slot   = '0;
                            n_out_ver    = '0;
                            n_out_status = STATUS_FULL;
                        end else begin
                            n_out_slot   = r_free_head[SLOT_W-1:0];
                            n_out_ver    = i_rd_data.version;
                            n_out_status = STATUS_OK;
                            if (i_rd_data.version != '0) begin
                                n_free_head = i_rd_data.link;
                            end else begin
                                n_free_head = r_free_head + LINK_W'(1);
                            end
                        end
                    end else begin
                        n_out_slot   = r_idx;
                        n_out_status = STATUS_OK;
                        if ({1'b0, r_idx} >= LINK_W'(SLOTS)) begin
                            n_out_ver = '0;
                        end else begin
                            o_ram_req.we = 1'b1;
                            n_out_ver    = bumped_ver;
                            n_free_head  = {1'b0, r_idx};
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_handle_slot    = r_out_slot;
    assign o_handle_version = r_out_ver;
    assign o_status         = r_out_status;

`ifndef SYNTHESIS
    // A completed destroy makes the destroyed slot the new free head.
    a_destroy_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && r_op == OP_DESTROY) |=> (r_free_head == {1'b0, $past(r_idx)}))
        else $error("free head does not point at the destroyed slot");

    // The slot memory is never written while waiting for a request.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_ram_req.we)
        else $error("slot memory written while idle");

    // A pending full status implies the free list is still exhausted.
    a_full_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_FULL) |-> (r_free_head >= LINK_W'(SLOTS)))
        else $error("full status reported with free slots available");

    // An accepted request always proceeds to the execute step.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_EXEC))
        else $error("accepted request did not reach execute");
`endif

endmodule

@@ rtl/versioned_handle_allocator_core.sv @@
// ----------------------------------------------------------------------------
// versioned_handle_allocator_core
// Generational handle allocator over a 1024-slot table with a free list.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_in_valid / o_in_ready    i_operation, i_slot_index
//   result    out        o_out_valid / i_out_ready  o_handle_slot,
//                                                   o_handle_version, o_status
//
// A request is accepted in ST_IDLE, which issues the slot memory read; ST_EXEC
// then uses the registered read data to write a destroyed slot back, update
// the free head and load the result register.
// After reset the version store is cleared by a pass over all 1024 slots, one slot
// per cycle, during which o_in_ready stays low.
// A new request is accepted while a previous result still waits in the result
// register; the execute step then holds until that result has been taken.
//
// Every request, create or destroy, produces exactly one result. A create
// pops the slot at the free head and returns its current version; a slot that
// was never used (version zero) advances the head to the next slot, while a
// recycled slot follows its stored link. A destroy bumps the version, links
// the slot to the old head and makes it the new head. When the head has run
// past the last slot, a create is refused with the full status and nothing
// changes.
// ----------------------------------------------------------------------------
module versioned_handle_allocator_core
    import vha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [SLOT_W-1:0] i_slot_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SLOT_W-1:0] o_handle_slot,
    output logic [VER_W-1:0]  o_handle_version,
    output logic              o_status
);

    // Memory access request and returned slot word between the two parts.
    t_ram_req   ram_req;
    t_slot_word rd_data;

    vha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_slot_index     (i_slot_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_handle_slot    (o_handle_slot),
        .o_handle_version (o_handle_version),
        .o_status         (o_status),
        .o_ram_req        (ram_req),
        .i_rd_data        (rd_data)
    );

    // The slot table holds link and version of each slot in one word.
    vha_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

endmodule

@@ tb/versioned_handle_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// versioned_handle_allocator_core_tb
// Self-checking bench for the versioned handle allocator core.
//
// A queue of create and destroy requests is filled up front. A clocked driver
// offers them one by one with random gaps, and a clocked monitor predicts the
// handle for every accepted request and checks it against the result that
// comes back. The sequence walks through handing out every slot, refusals on
// a full table, recycling through the free list, stray and double destroys,
// and finally a back-to-back burst of destroys on one slot.
// ----------------------------------------------------------------------------
module versioned_handle_allocator_core_tb;
    import vha_pkg::*;

    // Cycles with no request or result accepted before the run is declared
    // hung. This covers the reset clearing pass, the long deliberate receiver
    // hold and the longest random gaps, with room to spare.
    localparam int unsigned STALL_LIMIT = 4000;
    // Length of the one deliberate receiver hold that backs up the block.
    localparam int unsigned LONG_HOLD = 400;
    // Back-to-back destroys of one slot at the end of the run.
    localparam int unsigned BURST_RUN = 64;
    // Slot that the closing destroy burst hammers.
    localparam logic [SLOT_W-1:0] BURST_SLOT = 10'h155;
    // Cycles to keep watching after the last result, for anything extra.
    localparam int unsigned TAIL_CYCLES = 20;
    // Mismatch lines printed before the report goes quiet and only counts.
    localparam int unsigned PRINT_LIMIT = 100;

    // One request as the driver offers it, plus pacing hints for the driver.
    typedef struct {
        logic              op;
        logic [SLOT_W-1:0] idx;
        bit                back_to_back; // no gap after this request
        bit                wait_drain;   // offer only once every result is back
    } t_alloc_request;

    // One result as the block returns it.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [VER_W-1:0]  version;
        logic              status;
    } t_handle_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_operation = OP_CREATE;
    logic [SLOT_W-1:0] i_slot_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [SLOT_W-1:0] o_handle_slot;
    logic [VER_W-1:0]  o_handle_version;
    logic              o_status;

    versioned_handle_allocator_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_slot_index     (i_slot_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_handle_slot    (o_handle_slot),
        .o_handle_version (o_handle_version),
        .o_status         (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted allocator state. The version store starts cleared, as the
    // block clears it after reset. Links start at zero but are only ever read
    // for slots whose version is nonzero, which a destroy has written.
    // ------------------------------------------------------------------------
    logic [LINK_W-1:0] model_link    [SLOTS] = '{default: '0};
    logic [VER_W-1:0]  model_version [SLOTS] = '{default: '0};
    logic [LINK_W-1:0] model_head = '0;

    t_alloc_request request_backlog[$];
    t_handle_result expected_handles[$];
    t_alloc_request staged_request;
    t_handle_result oldest_handle;

    int unsigned mismatch_count   = 0;
    int unsigned handles_returned = 0;
    int unsigned idle_cycles      = 0;
    int unsigned cycle_no         = 0;
    int unsigned gap_left         = 0;
    int unsigned stall_left       = 0;
    int unsigned ready_roll;
    bit          request_taken    = 1'b0;
    bit          long_hold_done   = 1'b0;

    // Works out the handle that a request produces and advances the
    // predicted state. With a 10-bit slot index every destroy is in range,
    // so the out-of-range destroy case cannot be driven at this table size.
    function automatic t_handle_result predict_handle(input logic op,
                                                      input logic [SLOT_W-1:0] idx);
        t_handle_result    res;
        logic [SLOT_W-1:0] slot;
        res.slot    = '0;
        res.version = '0;
        res.status  = STATUS_OK;
        if (op == OP_CREATE) begin
            if (model_head >= LINK_W'(SLOTS)) begin
                // Free list exhausted: refused, nothing changes.
                res.status = STATUS_FULL;
            end else begin
                slot        = model_head[SLOT_W-1:0];
                res.slot    = slot;
                res.version = model_version[slot];
                // A slot that was never used has version zero and the next
                // free slot simply follows it; a recycled one follows its link.
                if (model_version[slot] != '0) begin
                    model_head = model_link[slot];
                end else begin
                    model_head = LINK_W'(slot) + LINK_W'(1);
                end
            end
        end else begin
            // Versions run up to all ones and then restart at one, skipping zero.
            if (model_version[idx] == '1) begin
                model_version[idx] = VER_W'(1);
            end else begin
                model_version[idx] = model_version[idx] + VER_W'(1);
            end
            model_link[idx] = model_head;
            model_head      = LINK_W'(idx);
            res.slot        = idx;
            res.version     = model_version[idx];
        end
        return res;
    endfunction

    // Prints one line per mismatch (up to a limit, so a badly broken block
    // does not flood the log) and counts every one of them.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic void queue_request(input logic op, input logic [SLOT_W-1:0] idx,
                                          input bit back_to_back, input bit wait_drain);
        t_alloc_request req;
        req.op           = op;
        req.idx          = idx;
        req.back_to_back = back_to_back;
        req.wait_drain   = wait_drain;
        request_backlog.push_back(req);
    endfunction

    // Neither side starts a random gap or stall inside a recurring calm window, so
    // the block also sees long stretches at full rate.
    function automatic bit in_calm_window();
        return (cycle_no % 1200) < 150;
    endfunction

    // Gap before the next request: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (in_calm_window() || roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Inputs change on the falling edge. A request stays on
    // the port, unchanged, until the monitor has seen it accepted; only then
    // does the driver count down its gap and move on to the next one.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !request_taken) begin
            // Still waiting for the block to take the current request.
        end else begin
            request_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (request_backlog.size() != 0 &&
                         !(request_backlog[0].wait_drain && expected_handles.size() != 0)) begin
                staged_request = request_backlog.pop_front();
                i_operation  <= staged_request.op;
                i_slot_index <= staged_request.idx;
                i_in_valid   <= 1'b1;
                gap_left = staged_request.back_to_back ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Mostly ready, with short random stalls and a few long
    // ones. Once, a good way into the run, it makes one long hold while the
    // driver keeps offering requests, so the result register fills and the block
    // has to stall its request side.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && handles_returned >= 600) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (in_calm_window()) begin
            i_out_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 18) begin
                stall_left = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else if (ready_roll < 20) begin
                stall_left = $urandom_range(15, 60);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. On each rising edge it checks an accepted result against the
    // oldest prediction, then predicts the result of an accepted request.
    // A result never comes out in the cycle its request is taken, so checking
    // before predicting keeps the order right.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                handles_returned++;
                if (expected_handles.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: slot %0d ver %0d st %0d",
                                              o_handle_slot, o_handle_version, o_status));
                end else begin
                    oldest_handle = expected_handles.pop_front();
                    if (o_handle_slot !== oldest_handle.slot) begin
                        report_mismatch($sformatf("result %0d slot %0d, expected %0d",
                                                  handles_returned, o_handle_slot,
                                                  oldest_handle.slot));
                    end
                    if (o_handle_version !== oldest_handle.version) begin
                        report_mismatch($sformatf("result %0d version %0d, expected %0d",
                                                  handles_returned, o_handle_version,
                                                  oldest_handle.version));
                    end
                    if (o_status !== oldest_handle.status) begin
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  handles_returned, o_status,
                                                  oldest_handle.status));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_handles.push_back(predict_handle(i_operation, i_slot_index));
                request_taken = 1'b1;
            end
        end
    end

    // Watchdog: ends the run if neither side makes progress for too long.
    always @(posedge i_clk) begin
        cycle_no++;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("versioned_handle_allocator_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int          live_slots[$];
        int          spare_slots[$];
        int          pick;
        int          s;
        bit          do_destroy;
        logic [SLOT_W-1:0] rand_idx;

        // Directed opening on a fresh table. The index on a create is ignored,
        // so it carries extreme patterns here. Slots 0..2 go out at version 0,
        // then 1 and 0 come back and are handed out again in last-in order,
        // and the untouched slot 3 follows. Slot 2 then makes one more round.
        queue_request(OP_CREATE,  10'h3FF, 1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h000, 1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h2AA, 1'b0, 1'b0);
        queue_request(OP_DESTROY, 10'd1,   1'b0, 1'b0);
        queue_request(OP_DESTROY, 10'd0,   1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h155, 1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h3FF, 1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h000, 1'b0, 1'b0);
        queue_request(OP_DESTROY, 10'd2,   1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h1FF, 1'b0, 1'b0);

        // The head now sits at slot 4. Hand out every remaining slot and then
        // keep asking, so the last few creates are refused as table full.
        for (int n = 0; n < SLOTS - 4 + 10; n++) begin
            queue_request(OP_CREATE, SLOT_W'($urandom), 1'b0, 1'b0);
        end

        // Every slot is now out. From here a simple mirror (the set of live
        // slots and a last-in-first-out stack of freed ones) is enough to
        // issue only well-formed destroys. The mix keeps the table close to
        // full, so refusals and recycling both come up often. The first
        // request waits until every earlier result has come back.
        for (int n = 0; n < SLOTS; n++) begin
            live_slots.push_back(n);
        end
        for (int n = 0; n < 600; n++) begin
            if (live_slots.size() == 0) begin
                do_destroy = 1'b0;
            end else if (spare_slots.size() == 0) begin
                do_destroy = ($urandom_range(0, 99) < 60);
            end else begin
                do_destroy = $urandom_range(0, 1);
            end
            if (do_destroy) begin
                pick = $urandom_range(0, live_slots.size() - 1);
                s    = live_slots[pick];
                live_slots.delete(pick);
                spare_slots.push_back(s);
                queue_request(OP_DESTROY, SLOT_W'(s), 1'b0, n == 0);
            end else begin
                if (spare_slots.size() != 0) begin
                    s = spare_slots.pop_back();
                    live_slots.push_back(s);
                end
                queue_request(OP_CREATE, SLOT_W'($urandom), 1'b0, n == 0);
            end
        end

        // Stray destroys. A destroy of a slot that is already free is carried
        // out like any other, so the free list ends up with the slot twice and
        // loops. This corrupts the list for good, which is why it comes late.
        queue_request(OP_DESTROY, 10'd0,   1'b0, 1'b0);
        queue_request(OP_DESTROY, 10'd1023, 1'b0, 1'b0);
        queue_request(OP_DESTROY, 10'd1023, 1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h2AA, 1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h155, 1'b0, 1'b0);
        queue_request(OP_CREATE,  10'h000, 1'b0, 1'b0);
        for (int n = 0; n < 300; n++) begin
            rand_idx = SLOT_W'($urandom);
            queue_request($urandom_range(0, 1) ? OP_DESTROY : OP_CREATE, rand_idx, 1'b0, 1'b0);
        end

        // A back-to-back burst of destroys on one slot, each one reading the
        // version that the one before has just written. A few creates close
        // the run.
        for (int n = 0; n < BURST_RUN; n++) begin
            queue_request(OP_DESTROY, BURST_SLOT, 1'b1, n == 0);
        end
        for (int n = 0; n < 4; n++) begin
            queue_request(OP_CREATE, SLOT_W'($urandom), 1'b0, 1'b0);
        end

        // Synchronous reset, released on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is in and every result has been checked,
        // then watch a little longer for anything unexpected.
        while (request_backlog.size() != 0 || i_in_valid || expected_handles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("versioned_handle_allocator_core test passed");
        end else begin
            $display("versioned_handle_allocator_core test failed");
        end
        $finish;
    end

endmodule
